/* hw/rtl/lode_pkg.sv */
package lode_pkg;

   // Fixed field widths
   localparam int VAL_W      = 32;   // Q16.16 state values
   localparam int STEP_W     = 16;   // Q0.16 step size
   localparam int COEF_W     = 24;   // Q8.16 normalized coefficients
   localparam int CNT_W      = 16;   // sample counter
   localparam int TIME_W     = 32;   // Q16.16 elapsed time
   localparam int N_IO       = 4;    // values carried on the ports
   localparam int MAX_ORDER  = 6;
   localparam int FRAC_W     = 16;

   // Wide accumulator: six 32x24 products plus negate and rounding
   localparam int SAT_W      = 60;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [STEP_W-1:0] STEP_SIZE_RESET = 16'd655;
   localparam logic [CNT_W-1:0]  RUN_STEPS_RESET = 16'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STEP_SIZE = 3'd0,
      REG_RUN_STEPS = 3'd1,
      REG_COEF_0    = 3'd2,
      REG_COEF_1    = 3'd3,
      REG_COEF_2    = 3'd4,
      REG_COEF_3    = 3'd5
   } reg_idx_type;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_STEP = 1'b1
   } func_type;

   // Clamp a wide signed value to signed 32 bit
   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SAT_W-1:0] x);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = {{(SAT_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
      lo = {{(SAT_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
      if (x > hi) begin
         sat_val = {1'b0, {(VAL_W-1){1'b1}}};
      end else if (x < lo) begin
         sat_val = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         sat_val = x[VAL_W-1:0];
      end
   endfunction

endpackage

/* hw/rtl/linear_ode_euler_stepper_core.sv */
// Channel   Dir  Handshake            Payload
// --------  ---  -------------------  ---------------------------------------------
// req       in   req_tvalid/tready    tuser: func; tdata: init_0..init_3
// rsp       out  rsp_tvalid/tready    tdata: value_0..3, top_derivative, elapsed;
//                                     tlast: done_res
// csr       in   csr_valid/csr_ready  csr_index, csr_data (always ready)
//
// Throughput is one beat per cycle while rsp is not stalled.
// Stage one is an input register. The state update and the result register load
// together when stage one advances, so a step sees the state left by the previous beat.
// The critical path is one 32x24 multiply bank plus the ORDER-term sum in the derivative unit.
// Synchronous active-high reset restores register defaults and clears the state.
// A stalled rsp holds its beat; the input register still takes one more req beat.
module linear_ode_euler_stepper_core #(
   parameter int ORDER = 4
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_tuser,   // [0] func
   input  logic [lode_pkg::N_IO*lode_pkg::VAL_W-1:0] req_tdata,
                                              // init_0, init_1, init_2, init_3

   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [(lode_pkg::N_IO+2)*lode_pkg::VAL_W-1:0] rsp_tdata,
                              // value_0, value_1, value_2, value_3, top_derivative, elapsed
   output logic                               rsp_tlast,   // done_res

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lode_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lode_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int VW = lode_pkg::VAL_W;
   localparam int NI = lode_pkg::N_IO;

   // Configuration registers
   logic        [lode_pkg::STEP_W-1:0] step_ff;
   logic        [lode_pkg::CNT_W-1:0]  run_ff;
   logic signed [lode_pkg::COEF_W-1:0] coef_ff [NI];

   // Input register
   logic                  in_valid_ff;
   lode_pkg::func_type    in_func_ff;
   logic signed [VW-1:0]  in_init_ff [NI];

   // Integrator state
   logic signed [VW-1:0]               val_ff [ORDER];
   logic signed [VW-1:0]               val_in [ORDER];
   logic signed [VW-1:0]               hd_ff;
   logic signed [VW-1:0]               hd_in;
   logic [lode_pkg::TIME_W-1:0]        time_ff;
   logic [lode_pkg::TIME_W-1:0]        time_in;
   logic [lode_pkg::CNT_W-1:0]         cnt_ff;
   logic [lode_pkg::CNT_W-1:0]         cnt_in;

   // Result register
   logic                                     out_valid_ff;
   logic [(NI+2)*VW-1:0]                     out_data_ff;
   logic [(NI+2)*VW-1:0]                     out_data_in;
   logic                                     out_last_ff;
   logic                                     out_last_in;

   logic signed [VW-1:0]               lane_next [ORDER];
   logic signed [lode_pkg::COEF_W-1:0] coef_lane [ORDER];
   logic signed [VW-1:0]               deriv_next;
   logic                               is_load;
   logic                               advance;
   logic [lode_pkg::TIME_W:0]          time_sum;
   logic [lode_pkg::CNT_W-1:0]         last_idx;

   // Stage one moves on when the result register is free or drains this cycle
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign is_load    = (in_func_ff == lode_pkg::FUNC_LOAD);

   // --- Euler lanes; top lane is fed by the highest derivative ---
   for (genvar k = 0; k < ORDER; k++) begin : g_lane
      logic signed [VW-1:0] upper;
      logic signed [VW-1:0] init_k;

      if (k + 1 < ORDER) begin : g_up
         assign upper = val_ff[k+1];
      end else begin : g_top
         assign upper = hd_ff;
      end

      if (k < NI) begin : g_io
         assign coef_lane[k] = coef_ff[k];
         assign init_k       = in_init_ff[k];
      end else begin : g_hidden
         // values beyond the port set load zero and carry no coefficient
         assign coef_lane[k] = '0;
         assign init_k       = '0;
      end

      lode_lane u_lane (
         .value      (val_ff[k]),
         .upper      (upper),
         .step_size  (step_ff),
         .value_next (lane_next[k])
      );

      assign val_in[k] = is_load ? init_k : lane_next[k];
   end

   lode_deriv #(
      .ORDER (ORDER)
   ) u_deriv (
      .values (val_ff),
      .coefs  (coef_lane),
      .deriv  (deriv_next)
   );

   assign hd_in = is_load ? '0 : deriv_next;

   // Saturating time accumulation
   assign time_sum = {1'b0, time_ff} + {{(lode_pkg::TIME_W+1-lode_pkg::STEP_W){1'b0}}, step_ff};
   assign time_in  = is_load ? '0 :
                     (time_sum[lode_pkg::TIME_W] ? '1 : time_sum[lode_pkg::TIME_W-1:0]);

   // Sample counter sticks at all ones
   assign cnt_in = is_load ? '0 : ((&cnt_ff) ? cnt_ff : cnt_ff + 1'b1);

   // run_steps of zero acts as one
   assign last_idx    = (run_ff == '0) ? '0 : run_ff - 1'b1;
   assign out_last_in = (cnt_in == last_idx);

   // --- Result packing ---
   for (genvar k = 0; k < NI; k++) begin : g_pack
      if (k < ORDER) begin : g_used
         assign out_data_in[k*VW +: VW] = val_in[k];
      end else begin : g_unused
         assign out_data_in[k*VW +: VW] = '0;
      end
   end
   assign out_data_in[NI*VW +: VW]     = hd_in;
   assign out_data_in[(NI+1)*VW +: VW] = time_in;

   // --- Configuration writes ---
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lode_pkg::STEP_SIZE_RESET;
         run_ff  <= lode_pkg::RUN_STEPS_RESET;
         for (int k = 0; k < NI; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lode_pkg::REG_STEP_SIZE: step_ff    <= csr_data[lode_pkg::STEP_W-1:0];
            lode_pkg::REG_RUN_STEPS: run_ff     <= csr_data[lode_pkg::CNT_W-1:0];
            lode_pkg::REG_COEF_0:    coef_ff[0] <= $signed(csr_data);
            lode_pkg::REG_COEF_1:    coef_ff[1] <= $signed(csr_data);
            lode_pkg::REG_COEF_2:    coef_ff[2] <= $signed(csr_data);
            lode_pkg::REG_COEF_3:    coef_ff[3] <= $signed(csr_data);
            default: ;   // unmapped index, dropped
         endcase
      end
   end

   // --- Input register ---
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff <= lode_pkg::func_type'(req_tuser);
         for (int k = 0; k < NI; k++) begin
            in_init_ff[k] <= $signed(req_tdata[k*VW +: VW]);
         end
      end
   end

   // --- State update, committed as the beat enters the result register ---
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ORDER; k++) begin
            val_ff[k] <= '0;
         end
         hd_ff   <= '0;
         time_ff <= '0;
         cnt_ff  <= '0;
      end else if (advance) begin
         for (int k = 0; k < ORDER; k++) begin
            val_ff[k] <= val_in[k];
         end
         hd_ff   <= hd_in;
         time_ff <= time_in;
         cnt_ff  <= cnt_in;
      end
   end

   // --- Result register ---
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

/* hw/rtl/lode_lane.sv */
// One Euler lane: value + upper * step, rounded, floor-shifted, saturated.
module lode_lane (
   input  logic signed [lode_pkg::VAL_W-1:0]  value,
   input  logic signed [lode_pkg::VAL_W-1:0]  upper,
   input  logic        [lode_pkg::STEP_W-1:0] step_size,
   output logic signed [lode_pkg::VAL_W-1:0]  value_next
);

   localparam int SUM_W = lode_pkg::VAL_W + lode_pkg::STEP_W + 2;

   logic signed [SUM_W-1:0] upper_ext;
   logic signed [SUM_W-1:0] step_ext;
   logic signed [SUM_W-1:0] prod;
   logic signed [SUM_W-1:0] value_sh;
   logic signed [SUM_W-1:0] half;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] shifted;

   assign upper_ext = $signed({{(SUM_W-lode_pkg::VAL_W){upper[lode_pkg::VAL_W-1]}}, upper});
   assign step_ext  = $signed({{(SUM_W-lode_pkg::STEP_W){1'b0}}, step_size});
   assign prod      = upper_ext * step_ext;
   assign value_sh  = $signed({{(SUM_W-lode_pkg::VAL_W-lode_pkg::FRAC_W){value[lode_pkg::VAL_W-1]}},
                               value, {lode_pkg::FRAC_W{1'b0}}});
   assign half      = $signed({{(SUM_W-lode_pkg::FRAC_W){1'b0}}, 1'b1,
                               {(lode_pkg::FRAC_W-1){1'b0}}});
   assign sum       = value_sh + prod + half;
   assign shifted   = sum >>> lode_pkg::FRAC_W;

   assign value_next = lode_pkg::sat_val(
      $signed({{(lode_pkg::SAT_W-SUM_W){shifted[SUM_W-1]}}, shifted}));

endmodule

/* hw/rtl/lode_deriv.sv */
// Highest derivative: -(sum of value * coef), rounded, floor-shifted, saturated.
module lode_deriv #(
   parameter int ORDER = 4
) (
   input  logic signed [lode_pkg::VAL_W-1:0]  values [ORDER],
   input  logic signed [lode_pkg::COEF_W-1:0] coefs  [ORDER],
   output logic signed [lode_pkg::VAL_W-1:0]  deriv
);

   localparam int PROD_W = lode_pkg::VAL_W + lode_pkg::COEF_W;

   logic signed [PROD_W-1:0]        prod [ORDER];
   logic signed [lode_pkg::SAT_W-1:0] acc;
   logic signed [lode_pkg::SAT_W-1:0] half;
   logic signed [lode_pkg::SAT_W-1:0] neg;
   logic signed [lode_pkg::SAT_W-1:0] shifted;

   for (genvar k = 0; k < ORDER; k++) begin : g_mul
      assign prod[k] =
         $signed({{(PROD_W-lode_pkg::VAL_W){values[k][lode_pkg::VAL_W-1]}}, values[k]}) *
         $signed({{(PROD_W-lode_pkg::COEF_W){coefs[k][lode_pkg::COEF_W-1]}}, coefs[k]});
   end

   always_comb begin
      acc = '0;
      for (int k = 0; k < ORDER; k++) begin
         acc = acc + $signed({{(lode_pkg::SAT_W-PROD_W){prod[k][PROD_W-1]}}, prod[k]});
      end
   end

   assign half    = $signed({{(lode_pkg::SAT_W-lode_pkg::FRAC_W){1'b0}}, 1'b1,
                             {(lode_pkg::FRAC_W-1){1'b0}}});
   assign neg     = half - acc;
   assign shifted = neg >>> lode_pkg::FRAC_W;
   assign deriv   = lode_pkg::sat_val(shifted);

endmodule

/* hw/rtl/lode_checker.sv */
// Port-level checks for the Euler stepper core.
module lode_checker (
   input logic                                              clock,
   input logic                                              reset,
   input logic                                              req_tvalid,
   input logic                                              req_tready,
   input logic                                              rsp_tvalid,
   input logic                                              rsp_tready,
   input logic [(lode_pkg::N_IO+2)*lode_pkg::VAL_W-1:0]     rsp_tdata,
   input logic                                              rsp_tlast
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // Nothing is presented right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // With the result register empty the input side never stalls
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty result register");

   // A beat taken during an rsp stall fills the input register: one slot only
   a_one_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && req_tvalid && req_tready |=> req_tready == rsp_tready)
      else $error("input register accepted past one pending beat");

endmodule

bind linear_ode_euler_stepper_core lode_checker u_lode_checker (.*);
